### rtl/prn_pkg.sv
// Package for the Poisson residual norm block: constants, register indexes
// and the command/status structs between controller and datapath. No dependencies.
package prn_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;

  localparam int VAL_W  = 32;   // Q16.16 pressure and rhs
  localparam int SUM_W  = 64;   // Q32.32 sum
  localparam int GCOL_W = 11;   // grid_columns register
  localparam int GROW_W = 16;   // grid_rows register and row counter
  localparam int NX_W   = 35;   // second difference of three Q16.16 values
  localparam int PROD_W = 52;   // NX_W times a 17-bit signed half of a scale
  localparam int LAP_W  = 68;   // sum of four shifted partial products
  localparam int RES_W  = 69;   // residual before rounding
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_GRID_COLUMNS = 2'd0;
  localparam logic [1:0] REG_GRID_ROWS    = 2'd1;
  localparam logic [1:0] REG_INV_DX_SQ    = 2'd2;
  localparam logic [1:0] REG_INV_DY_SQ    = 2'd3;

  localparam logic [GCOL_W-1:0] GRID_COLUMNS_RST = 11'd3;
  localparam logic [GROW_W-1:0] GRID_ROWS_RST    = 16'd3;
  localparam logic [VAL_W-1:0]  INV_SQ_RST       = 32'h0001_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       cap_in;      // take the accepted cell into the datapath
    logic       rd_second;   // second read pair (right and upper neighbors)
    logic       cap_first;   // capture center, left and rhs/flag
    logic       cap_second;  // capture right and upper, form both differences
    logic       mem_we;      // update the three line buffers
    logic       mul_en;      // multiply one partial product
    logic [1:0] mul_sel;     // bit 1: row direction, bit 0: upper scale half
    logic       acc_en;      // add the last partial product into the Laplacian
    logic       res_en;      // round and clamp the residual
    logic       sq_en;       // square the residual magnitude
    logic       sum_en;      // add the square into the saturating sum
    logic       sum_clr;     // start a new grid
    logic       out_load;    // load the output register
  } cmd_t;

  typedef struct packed {
    logic fluid;             // flag of the center cell just read
  } stat_t;

endpackage

### rtl/poisson_residual_norm.sv
// Channel   Dir  Fields (lowest bit first)
// in_       in   tdata: pressure, rhs_value; tuser: is_fluid; tlast: last_cell
// out_      out  tdata: residual_norm_squared; tuser: saturated
// cfg_      in   APB registers grid_columns, grid_rows, inv_dx_squared, inv_dy_squared
//
// A cell that is not evaluated only passes the read and write states; an interior
// fluid cell also steps the shared multiplier four times per residual, then rounds,
// squares and sums, and only then is the next cell taken. Reset (rst_n, synchronous)
// clears counters, sum and flags; line buffers are not cleared. A result waiting
// in the output register does not stall input; only the next last cell waits for it.
//
// Top level of the Poisson residual norm block. Holds the configuration registers
// and joins prn_ctrl and prn_dp. Depends on prn_pkg, prn_ctrl, prn_dp, prn_ram.
module poisson_residual_norm #(
  parameter int MAX_COLUMNS = prn_pkg::MAX_COLUMNS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: pressure [31:0], rhs_value [63:32]
  input  logic [63:0]                 in_tdata,
  // in_tuser: is_fluid [0]
  input  logic                        in_tuser,
  input  logic                        in_tlast,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // out_tdata: residual_norm_squared [63:0]
  output logic [63:0]                 out_tdata,
  // out_tuser: saturated [0]
  output logic                        out_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [prn_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [prn_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [prn_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import prn_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);

  logic [GCOL_W-1:0] grid_columns_r, grid_columns_nxt;
  logic [GROW_W-1:0] grid_rows_r, grid_rows_nxt;
  logic [VAL_W-1:0]  inv_dx_sq_r, inv_dx_sq_nxt;
  logic [VAL_W-1:0]  inv_dy_sq_r, inv_dy_sq_nxt;

  logic              cfg_wr;
  logic [1:0]        reg_idx;
  logic [CW-1:0]     col_addr;
  cmd_t              cmd;
  stat_t             stat;

  // Registers sit at byte addresses 4*i; a write completes in the access phase.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_comb begin
    grid_columns_nxt = grid_columns_r;
    grid_rows_nxt    = grid_rows_r;
    inv_dx_sq_nxt    = inv_dx_sq_r;
    inv_dy_sq_nxt    = inv_dy_sq_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_GRID_COLUMNS: grid_columns_nxt = cfg_pwdata[GCOL_W-1:0];
        REG_GRID_ROWS:    grid_rows_nxt    = cfg_pwdata[GROW_W-1:0];
        REG_INV_DX_SQ:    inv_dx_sq_nxt    = cfg_pwdata;
        REG_INV_DY_SQ:    inv_dy_sq_nxt    = cfg_pwdata;
        default:          grid_columns_nxt = grid_columns_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRID_COLUMNS: cfg_prdata = APB_DW'(grid_columns_r);
      REG_GRID_ROWS:    cfg_prdata = APB_DW'(grid_rows_r);
      REG_INV_DX_SQ:    cfg_prdata = inv_dx_sq_r;
      REG_INV_DY_SQ:    cfg_prdata = inv_dy_sq_r;
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_columns_r <= GRID_COLUMNS_RST;
      grid_rows_r    <= GRID_ROWS_RST;
      inv_dx_sq_r    <= INV_SQ_RST;
      inv_dy_sq_r    <= INV_SQ_RST;
    end else begin
      grid_columns_r <= grid_columns_nxt;
      grid_rows_r    <= grid_rows_nxt;
      inv_dx_sq_r    <= inv_dx_sq_nxt;
      inv_dy_sq_r    <= inv_dy_sq_nxt;
    end
  end

  // The controller walks each transfer through read, write and, for interior
  // fluid cells, the multiply, round, square and sum steps.
  prn_ctrl #(.MAX_COLUMNS(MAX_COLUMNS)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .grid_columns (grid_columns_r),
    .grid_rows    (grid_rows_r),
    .in_tvalid    (in_tvalid),
    .in_tlast     (in_tlast),
    .in_tready    (in_tready),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .col_addr     (col_addr),
    .cmd          (cmd),
    .stat         (stat)
  );

  prn_dp #(.MAX_COLUMNS(MAX_COLUMNS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_pressure    (in_tdata[31:0]),
    .in_rhs         (in_tdata[63:32]),
    .in_fluid       (in_tuser),
    .inv_dx_squared (inv_dx_sq_r),
    .inv_dy_squared (inv_dy_sq_r),
    .col_addr       (col_addr),
    .cmd            (cmd),
    .stat           (stat),
    .out_sum        (out_tdata),
    .out_sat        (out_tuser)
  );

endmodule

### rtl/prn_ram.sv
// Generic simple dual-port RAM with registered read, used for the line buffers.
// No dependencies.
module prn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/prn_ctrl.sv
// Controller of the Poisson residual norm block: item sequencing, grid position
// counters, interior test and output valid. Depends on prn_pkg.
module prn_ctrl #(
  parameter int MAX_COLUMNS = prn_pkg::MAX_COLUMNS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [prn_pkg::GCOL_W-1:0]     grid_columns,
  input  logic [prn_pkg::GROW_W-1:0]     grid_rows,
  input  logic                           in_tvalid,
  input  logic                           in_tlast,
  output logic                           in_tready,
  input  logic                           out_tready,
  output logic                           out_tvalid,
  output logic [$clog2(MAX_COLUMNS)-1:0] col_addr,
  output prn_pkg::cmd_t                  cmd,
  input  prn_pkg::stat_t                 stat
);
  import prn_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int XW = CW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0  = 4'd1;
  localparam logic [3:0] S_RD1  = 4'd2;
  localparam logic [3:0] S_WR   = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_RES  = 4'd5;
  localparam logic [3:0] S_SQ   = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [GROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]     c_r, c_nxt;
  logic              eval_r, eval_nxt;
  logic              last_r, last_nxt;
  logic [2:0]        mcnt_r, mcnt_nxt;
  logic              ovalid_r, ovalid_nxt;

  logic [XW-1:0]     cols_eff;
  logic [GROW_W-1:0] rows_eff;
  logic [CW-1:0]     c_cur;
  logic [XW-1:0]     c_cur_p1;
  logic [XW-1:0]     c_r_p1;
  logic              accept;
  logic              fin_go;

  // Out-of-range register values are clamped into the usable range.
  always_comb begin
    if (32'(grid_columns) > 32'(MAX_COLUMNS)) begin
      cols_eff = XW'(MAX_COLUMNS);
    end else if (grid_columns < 11'd3) begin
      cols_eff = XW'(3);
    end else begin
      cols_eff = XW'(grid_columns);
    end
    rows_eff = (grid_rows < 16'd3) ? 16'd3 : grid_rows;
  end

  assign c_cur    = ({1'b0, col_r} >= cols_eff) ? '0 : col_r;
  assign c_cur_p1 = {1'b0, c_cur} + XW'(1);
  assign c_r_p1   = {1'b0, c_r} + XW'(1);

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign fin_go     = !last_r || !ovalid_r || out_tready;
  assign out_tvalid = ovalid_r;
  assign col_addr   = c_r;

  always_comb begin
    state_nxt  = state_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    c_nxt      = c_r;
    eval_nxt   = eval_r;
    last_nxt   = last_r;
    mcnt_nxt   = mcnt_r;
    ovalid_nxt = ovalid_r && !out_tready;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.cap_in = 1'b1;
          c_nxt      = c_cur;
          last_nxt   = in_tlast;
          eval_nxt   = (row_r >= 16'd2) && (row_r <= rows_eff - 16'd1) &&
                       (c_cur != '0) && (c_cur_p1 < cols_eff);
          state_nxt  = S_RD0;
        end
      end
      S_RD0: begin
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.cap_first = 1'b1;
        cmd.rd_second = 1'b1;
        state_nxt     = S_WR;
      end
      S_WR: begin
        cmd.cap_second = 1'b1;
        cmd.mem_we     = 1'b1;
        mcnt_nxt       = '0;
        state_nxt      = (eval_r && stat.fluid) ? S_MUL : S_FIN;
      end
      S_MUL: begin
        // Four partial products, each added in the cycle after it is formed.
        cmd.mul_en  = (mcnt_r != 3'd4);
        cmd.mul_sel = mcnt_r[1:0];
        cmd.acc_en  = (mcnt_r != 3'd0);
        mcnt_nxt    = mcnt_r + 3'd1;
        if (mcnt_r == 3'd4) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        cmd.res_en = 1'b1;
        state_nxt  = S_SQ;
      end
      S_SQ: begin
        cmd.sq_en = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.sum_en = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
          if (last_r) begin
            cmd.out_load = 1'b1;
            cmd.sum_clr  = 1'b1;
            ovalid_nxt   = 1'b1;
            col_nxt      = '0;
            row_nxt      = '0;
          end else if (c_r_p1 >= cols_eff) begin
            col_nxt = '0;
            row_nxt = (row_r != 16'hFFFF) ? row_r + 16'd1 : row_r;
          end else begin
            col_nxt = c_r_p1[CW-1:0];
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      col_r    <= '0;
      row_r    <= '0;
      c_r      <= '0;
      eval_r   <= 1'b0;
      last_r   <= 1'b0;
      mcnt_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      c_r      <= c_nxt;
      eval_r   <= eval_nxt;
      last_r   <= last_nxt;
      mcnt_r   <= mcnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

### rtl/prn_dp.sv
// Datapath of the Poisson residual norm block: three line buffers, stencil
// differences, shared multiplier, rounding, squaring and saturating sum.
// Depends on prn_pkg and prn_ram.
module prn_dp #(
  parameter int MAX_COLUMNS = prn_pkg::MAX_COLUMNS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [prn_pkg::VAL_W-1:0]      in_pressure,
  input  logic [prn_pkg::VAL_W-1:0]      in_rhs,
  input  logic                           in_fluid,
  input  logic [prn_pkg::VAL_W-1:0]      inv_dx_squared,
  input  logic [prn_pkg::VAL_W-1:0]      inv_dy_squared,
  input  logic [$clog2(MAX_COLUMNS)-1:0] col_addr,
  input  prn_pkg::cmd_t                  cmd,
  output prn_pkg::stat_t                 stat,
  output logic [prn_pkg::SUM_W-1:0]      out_sum,
  output logic                           out_sat
);
  import prn_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);

  logic [VAL_W-1:0]      p_in_r;
  logic [VAL_W:0]        rf_in_r;
  logic [VAL_W-1:0]      pc_r, pl_r, rhs_r;
  logic                  fluid_r;
  logic signed [NX_W-1:0]   nx_r, ny_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                  prod_hi_r;
  logic signed [LAP_W-1:0]  lap_r;
  logic [VAL_W-1:0]      mag_r;
  logic [SUM_W-1:0]      sq_r;
  logic [SUM_W-1:0]      sum_r;
  logic                  sat_r;
  logic [SUM_W-1:0]      out_sum_r;
  logic                  out_sat_r;

  logic [CW-1:0]         ctr_raddr, abv_raddr;
  logic [VAL_W-1:0]      ctr_q, abv_q;
  logic [VAL_W:0]        rf_q;

  logic signed [NX_W-1:0]   nx_nxt, ny_nxt;
  logic signed [NX_W-1:0]   mul_a;
  logic [15:0]              mul_k;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [LAP_W-1:0]  prod_ext;
  logic signed [RES_W-1:0]  res;
  logic [RES_W-17:0]        rnd;
  logic                     rnd_fits;
  logic [VAL_W-1:0]         mag_nxt;
  logic [SUM_W:0]           sum_add;

  // First read pair: center and left; second pair: right and upper.
  assign ctr_raddr = cmd.rd_second ? col_addr + CW'(1) : col_addr;
  assign abv_raddr = cmd.rd_second ? col_addr : col_addr - CW'(1);

  prn_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLUMNS)) u_row_above (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (col_addr),
    .wdata (pc_r),
    .raddr (abv_raddr),
    .rdata (abv_q)
  );

  prn_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLUMNS)) u_row_center (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (col_addr),
    .wdata (p_in_r),
    .raddr (ctr_raddr),
    .rdata (ctr_q)
  );

  prn_ram #(.WIDTH(VAL_W + 1), .DEPTH(MAX_COLUMNS)) u_rhs_flag (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (col_addr),
    .wdata (rf_in_r),
    .raddr (col_addr),
    .rdata (rf_q)
  );

  assign stat.fluid = fluid_r;

  // Second differences in both directions, the new cell being the lower neighbor.
  assign nx_nxt = NX_W'($signed(pl_r)) + NX_W'($signed(ctr_q))
                  - (NX_W'($signed(pc_r)) <<< 1);
  assign ny_nxt = NX_W'($signed(abv_q)) + NX_W'($signed(p_in_r))
                  - (NX_W'($signed(pc_r)) <<< 1);

  // Each scale is split into 16-bit halves to keep the multiplier narrow.
  always_comb begin
    mul_a = cmd.mul_sel[1] ? ny_r : nx_r;
    unique case (cmd.mul_sel)
      2'd0:    mul_k = inv_dx_squared[15:0];
      2'd1:    mul_k = inv_dx_squared[31:16];
      2'd2:    mul_k = inv_dy_squared[15:0];
      default: mul_k = inv_dy_squared[31:16];
    endcase
  end

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_k}));
  assign prod_ext = prod_hi_r ? $signed({prod_r, 16'h0000})
                              : $signed({{(LAP_W - PROD_W){prod_r[PROD_W-1]}}, prod_r});

  // Residual in Q32.32 plus one half, then floor to Q16.16 and clamp.
  assign res = $signed({{(RES_W - VAL_W - 16){rhs_r[VAL_W-1]}}, rhs_r, 16'h0000})
               - $signed({lap_r[LAP_W-1], lap_r})
               + RES_W'(32'h0000_8000);
  assign rnd      = res[RES_W-1:16];
  assign rnd_fits = (&rnd[RES_W-17:VAL_W-1]) || !(|rnd[RES_W-17:VAL_W-1]);

  always_comb begin
    if (!rnd_fits) begin
      mag_nxt = res[RES_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (res[RES_W-1]) begin
      mag_nxt = ~rnd[VAL_W-1:0] + 32'd1;
    end else begin
      mag_nxt = rnd[VAL_W-1:0];
    end
  end

  assign sum_add = {1'b0, sum_r} + {1'b0, sq_r};

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      p_in_r  <= in_pressure;
      rf_in_r <= {in_fluid, in_rhs};
    end
    if (cmd.cap_first) begin
      pc_r    <= ctr_q;
      pl_r    <= abv_q;
      rhs_r   <= rf_q[VAL_W-1:0];
      fluid_r <= rf_q[VAL_W];
    end
    if (cmd.cap_second) begin
      nx_r <= nx_nxt;
      ny_r <= ny_nxt;
    end
    if (cmd.mul_en) begin
      prod_r    <= prod_nxt;
      prod_hi_r <= cmd.mul_sel[0];
    end
    if (cmd.cap_second) begin
      lap_r <= '0;
    end else if (cmd.acc_en) begin
      lap_r <= lap_r + prod_ext;
    end
    if (cmd.res_en) begin
      mag_r <= mag_nxt;
    end
    if (cmd.sq_en) begin
      sq_r <= 64'(mag_r) * 64'(mag_r);
    end
    if (cmd.out_load) begin
      out_sum_r <= sum_r;
      out_sat_r <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      sat_r <= 1'b0;
    end else if (cmd.sum_clr) begin
      sum_r <= '0;
      sat_r <= 1'b0;
    end else begin
      if (cmd.res_en && !rnd_fits) begin
        sat_r <= 1'b1;
      end
      if (cmd.sum_en) begin
        if (sum_add[SUM_W]) begin
          sum_r <= '1;
          sat_r <= 1'b1;
        end else begin
          sum_r <= sum_add[SUM_W-1:0];
        end
      end
    end
  end

  assign out_sum = out_sum_r;
  assign out_sat = out_sat_r;

endmodule

### sim/poisson_residual_norm_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for poisson_residual_norm: streams pressure grids through
// the cell channel and compares each grid's squared residual norm with a bit-exact
// predictor. Depends on prn_pkg and the poisson_residual_norm RTL.
module poisson_residual_norm_tb;
  import prn_pkg::*;

  localparam int NCOL         = MAX_COLUMNS_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int LONG_HOLD    = 1500;  // receiver hold-off that backs up the block
  localparam int DRAIN_CYCLES = 40;    // idle margin after the last norm for a cell still in flight
  localparam int PHASE_ITEMS  = 90;

  // One grid cell as it travels on the input channel.
  typedef struct packed {
    logic [31:0] pressure;
    logic [31:0] rhs;
    logic        fluid;
    logic        last;
  } cell_t;

  // One grid result: the saturating Q32.32 sum and its saturation flag.
  typedef struct packed {
    logic [63:0] norm;
    logic        sat;
  } norm_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic [63:0]       in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              in_tlast = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [63:0]       out_tdata;
  logic              out_tuser;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  poisson_residual_norm dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Cells waiting to be offered, and grid norms predicted but not yet seen.
  cell_t cell_queue[$];
  norm_t norm_queue[$];

  int unsigned idle_pct = 0;      // chance in percent that a side starts an idle burst
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // ---------------------------------------------------------------------------
  // Stencil predictor. It mirrors the block's line buffers, raster counters,
  // saturating sum and its own copy of the four configuration registers.
  // ---------------------------------------------------------------------------
  logic [31:0]       row_above    [NCOL];
  logic [31:0]       row_center   [NCOL];
  logic [32:0]       row_rhs_flag [NCOL];  // {is_fluid, rhs} of the row being evaluated
  int unsigned       col_pos;
  int unsigned       row_pos;
  logic [63:0]       norm_sum;
  logic              norm_sat;
  logic [GCOL_W-1:0] m_cols;
  logic [GROW_W-1:0] m_rows;
  logic [31:0]       m_dx;
  logic [31:0]       m_dy;

  // Residual of the center cell in column c of the row above the arriving one.
  // The arithmetic is carried out at 128 bits, so the Laplacian is exact before
  // the residual is rounded half up to Q16.16 and clamped to signed 32 bits.
  function automatic void add_residual(int unsigned c, logic [31:0] below);
    logic signed [127:0] center, nx, ny, scale_x, scale_y, res, q;
    logic [127:0]        neg_q;
    logic [63:0]         mag, sq;
    logic [64:0]         total;
    center  = $signed(row_center[c]);
    // The left neighbor has already moved into the upper buffer in this row.
    nx      = $signed(row_above[c-1]) + $signed(row_center[c+1]) - 2 * center;
    ny      = $signed(row_above[c]) + $signed(below) - 2 * center;
    scale_x = {96'd0, m_dx};
    scale_y = {96'd0, m_dy};
    res     = $signed(row_rhs_flag[c][31:0]) * 65536 - (nx * scale_x + ny * scale_y) + 32768;
    q       = res >>> 16;
    if (q > 2147483647) begin
      norm_sat = 1'b1;
      mag      = 64'h7FFF_FFFF;
    end else if (q < -64'sd2147483648) begin
      norm_sat = 1'b1;
      mag      = 64'h8000_0000;
    end else if (q < 0) begin
      neg_q = -q;
      mag   = neg_q[63:0];
    end else begin
      mag = q[63:0];
    end
    sq    = mag * mag;
    total = {1'b0, norm_sum} + {1'b0, sq};
    if (total[64]) begin
      norm_sum = '1;
      norm_sat = 1'b1;
    end else begin
      norm_sum = total[63:0];
    end
  endfunction

  // Advances the predictor by one accepted cell; returns 1 when a norm is due.
  function automatic bit predict_cell(cell_t item, output norm_t result);
    int unsigned cols, rows, c;
    cols = (m_cols < 3) ? 3 : m_cols;
    if (cols > NCOL) cols = NCOL;
    rows = (m_rows < 3) ? 3 : m_rows;
    c = col_pos;
    if (c >= cols) c = 0;
    if (row_pos >= 2 && row_pos <= rows - 1 && c >= 1 && c + 1 < cols && row_rhs_flag[c][32])
      add_residual(c, item.pressure);
    row_above[c]    = row_center[c];
    row_center[c]   = item.pressure;
    row_rhs_flag[c] = {item.fluid, item.rhs};
    if (c + 1 >= cols) begin
      col_pos = 0;
      if (row_pos < 65535) row_pos++;
    end else begin
      col_pos = c + 1;
    end
    result = '0;
    if (item.last) begin
      result.norm = norm_sum;
      result.sat  = norm_sat;
      norm_sum    = '0;
      norm_sat    = 1'b0;
      row_pos     = 0;
      col_pos     = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Cell driver. Each accepted transfer is handed to the predictor at the edge
  // where it completes, then the next cell from the queue is put on the bus or
  // an idle burst is started. tvalid gets at most one nonblocking assignment
  // per edge, so back-to-back cells keep it high.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    norm_t predicted;
    cell_t next;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (predict_cell({in_tdata[31:0], in_tdata[63:32], in_tuser, in_tlast}, predicted))
          norm_queue.push_back(predicted);
      end
      if (!(in_tvalid && !in_tready)) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (cell_queue.size() > 0 && $urandom_range(0, 99) < idle_pct) begin
          send_gap  <= $urandom_range(0, 9);
          in_tvalid <= 1'b0;
        end else if (cell_queue.size() > 0) begin
          next = cell_queue.pop_front();
          in_tdata  <= {next.rhs, next.pressure};
          in_tuser  <= next.fluid;
          in_tlast  <= next.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver readiness. A single long hold-off, requested by the stimulus,
  // lets a finished norm sit in the output register while further grids arrive,
  // so the next last cell has to wait and the input channel backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap   <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left  <= LONG_HOLD;
      hold_done  <= 1'b1;
      out_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap   <= recv_gap - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      recv_gap   <= $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic report_error(string what, norm_t want, norm_t got);
    errors++;
    if (errors <= 10)
      $display("ERROR %s: expected norm %h sat %b, got norm %h sat %b",
               what, want.norm, want.sat, got.norm, got.sat);
  endtask

  // Result monitor: every accepted transfer is matched against the oldest
  // predicted norm, field by field.
  always @(posedge clk) begin
    norm_t want;
    norm_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.norm = out_tdata;
      got.sat  = out_tuser;
      if (norm_queue.size() == 0) begin
        report_error("result with nothing pending", '0, got);
      end else begin
        want = norm_queue.pop_front();
        if (got.norm !== want.norm || got.sat !== want.sat)
          report_error("norm mismatch", want, got);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // APB write: setup cycle, then access cycle; the register takes the value at
  // the edge where the access phase meets pready.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_GRID_COLUMNS: m_cols = value[GCOL_W-1:0];
      REG_GRID_ROWS:    m_rows = value[GROW_W-1:0];
      REG_INV_DX_SQ:    m_dx   = value;
      REG_INV_DY_SQ:    m_dy   = value;
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic [31:0] cols, input logic [31:0] rows,
                          input logic [31:0] dx, input logic [31:0] dy);
    reg_write(REG_GRID_COLUMNS, cols);
    reg_write(REG_GRID_ROWS, rows);
    reg_write(REG_INV_DX_SQ, dx);
    reg_write(REG_INV_DY_SQ, dy);
  endtask

  // Waits until every cell is sent and every norm has arrived, then lets the
  // block finish any cell still in flight.
  task automatic drain();
    while (cell_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (norm_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_cell(input logic [31:0] p, input logic [31:0] rhs,
                           input logic fluid, input logic last);
    cell_t item;
    item.pressure = p;
    item.rhs      = rhs;
    item.fluid    = fluid;
    item.last     = last;
    cell_queue.push_back(item);
  endtask

  // Mode 0 gives small values that keep most residuals in range, mode 1 any
  // 32-bit pattern, mode 2 the signed Q16.16 extremes, zero, all ones or any pattern.
  function automatic logic [31:0] pick_value(int unsigned mode);
    case (mode)
      0: return $urandom_range(0, 32'h7FFFF) - 32'h40000;
      1: return $urandom();
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 4))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return INV_SQ_RST;
      3: return $urandom_range(0, 32'h10_0000);
      default: return $urandom();
    endcase
  endfunction

  // A run of n cells with random content; the final one carries last_cell.
  task automatic push_grid(input int unsigned n, input int unsigned mode);
    for (int unsigned i = 0; i < n; i++)
      push_cell(pick_value(mode), pick_value(mode), $urandom_range(0, 3) != 0, i == n - 1);
  endtask

  // Grids for the current setting until the budget of cells is used. Most are
  // complete; some end early or run past the last row. A huge row count is
  // never filled, so those grids always end early.
  task automatic random_grids(input int unsigned budget);
    int unsigned ec, er, n, used;
    ec = (m_cols < 3) ? 3 : ((m_cols > NCOL) ? NCOL : m_cols);
    er = (m_rows < 3) ? 3 : m_rows;
    used = 0;
    while (used < budget) begin
      n = ec * ((er > 12) ? $urandom_range(3, 6) : er);
      case ($urandom_range(0, 9))
        0: n = $urandom_range(1, n - 1);
        1: n = n + $urandom_range(1, 2 * ec);
        default: ;
      endcase
      push_grid(n, $urandom_range(0, 2));
      used += n;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    m_cols   = GRID_COLUMNS_RST;
    m_rows   = GRID_ROWS_RST;
    m_dx     = INV_SQ_RST;
    m_dy     = INV_SQ_RST;
    col_pos  = 0;
    row_pos  = 0;
    norm_sum = '0;
    norm_sat = 1'b0;
    idle_pct = 15;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed grids at the reset setting (3 by 3, unit scales). First a fluid
    // center at the most negative pressure with all four neighbors at the most
    // positive one, which drives the residual past the signed range.
    for (int i = 0; i < 9; i++)
      push_cell((i == 4) ? 32'h8000_0000 : ((i % 2 == 1) ? 32'h7FFF_FFFF : 32'h0),
                (i == 4) ? 32'h7FFF_FFFF : 32'h0, i == 4, i == 8);
    // Flat pressure with the most negative rhs: the residual is exactly the
    // lower bound, which still fits and squares to 2^62.
    for (int i = 0; i < 9; i++)
      push_cell(32'h0, (i == 4) ? 32'h8000_0000 : $urandom(), i == 4, i == 8);
    // A grid cut short after three cells yields an empty sum.
    for (int i = 0; i < 3; i++)
      push_cell(pick_value(2), pick_value(2), 1'b1, i == 2);
    drain();

    // Random phases, each under its own setting. The first ones cover the
    // register extremes: sizes below the minimum, zero and full-scale
    // spacings, and a row count far beyond any grid that is sent.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_grid(0, 0, 32'hFFFF_FFFF, 32'h0);
        1: set_grid(1, 2, 32'h0, 32'hFFFF_FFFF);
        2: set_grid($urandom_range(3, 12), 65535, INV_SQ_RST, INV_SQ_RST);
        3: set_grid(3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: set_grid($urandom_range(3, 12), $urandom_range(3, 8), pick_scale(), pick_scale());
      endcase
      idle_pct = (phase % 3 == 2) ? 0 : 15;
      random_grids(PHASE_ITEMS);
      drain();
    end

    // Backpressure: the receiver holds off while many small grids follow.
    idle_pct = 15;
    set_grid(3, 3, INV_SQ_RST, INV_SQ_RST);
    hold_req <= 1'b1;
    for (int g = 0; g < 24; g++)
      push_grid(9, $urandom_range(0, 2));
    drain();

    // Closing phase with both sides running flat out.
    idle_pct = 0;
    set_grid($urandom_range(3, 12), $urandom_range(3, 8), pick_scale(), pick_scale());
    random_grids(PHASE_ITEMS);
    drain();

    if (errors == 0 && norm_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
rtl/prn_pkg.sv
rtl/prn_ram.sv
rtl/prn_ctrl.sv
rtl/prn_dp.sv
rtl/poisson_residual_norm.sv
sim/poisson_residual_norm_tb.sv
